// ===== rtl/differential_drive_odometry_core_macros.svh =====
// assertion macros shared by the odometry checker
// no other dependencies
`ifndef DIFFERENTIAL_DRIVE_ODOMETRY_CORE_MACROS_SVH
`define DIFFERENTIAL_DRIVE_ODOMETRY_CORE_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define DDO_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is low
`define DDO_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/ddo_pkg.sv =====
// shared types, constants and tables of the odometry core
// no dependencies
package ddo_pkg;

    // configuration register indexes
    typedef enum logic [1:0] {
        CFG_LEFT_SCALE  = 2'd0,
        CFG_RIGHT_SCALE = 2'd1,
        CFG_HALF_TRACK  = 2'd2
    } t_cfg_index;

    localparam logic [23:0] RST_LEFT_SCALE  = 24'd655360;
    localparam logic [23:0] RST_RIGHT_SCALE = 24'd655360;
    localparam logic [23:0] RST_HALF_TRACK  = 24'd25600;

    // fixed-point constants
    localparam logic signed [33:0] CORDIC_GAIN     = 34'sd652032875;
    localparam logic signed [33:0] RAD_TO_BAM_HALF = 34'sd341782638;
    localparam logic signed [33:0] BAM_TO_INV_PI   = 34'sd683565276;
    localparam logic signed [33:0] SERIES_K        = 34'sd107802;

    // item payloads
    typedef struct packed {
        logic signed [31:0] left_angle;
        logic signed [31:0] right_angle;
    } t_odo_in;

    typedef struct packed {
        logic signed [31:0] x_position;
        logic signed [31:0] y_position;
        logic        [31:0] heading;
        logic               pose_saturated;
    } t_odo_out;

    // multiplier operand selection
    typedef enum logic [3:0] {
        MUL_NONE,
        MUL_L,
        MUL_R,
        MUL_H,
        MUL_HK,
        MUL_HKH,
        MUL_SB,
        MUL_LRF,
        MUL_CX,
        MUL_CY
    } t_mul_op;

    // controller states
    typedef enum logic [4:0] {
        S_IDLE,
        S_ML,
        S_MR,
        S_RD,
        S_MH,
        S_D1S,
        S_D1W,
        S_SEL,
        S_MK,
        S_MKH,
        S_FS,
        S_C1W,
        S_MSB,
        S_D2S,
        S_D2W,
        S_MC,
        S_CC,
        S_C2W,
        S_MX,
        S_MY,
        S_FIN
    } t_odo_state;

    // controller to datapath commands
    typedef struct packed {
        t_mul_op mul_op;
        logic    cap_in;
        logic    ld_l;
        logic    ld_r;
        logic    div_start;
        logic    div_for_f;
        logic    ld_h;
        logic    ld_f_small;
        logic    ld_f_div;
        logic    cor_start;
        logic    cor_dir;
        logic    ld_c;
        logic    ld_x;
        logic    commit;
    } t_odo_cmd;

    // datapath to controller status
    typedef struct packed {
        logic div_done;
        logic cor_done;
        logic small_turn;
        logic out_free;
    } t_odo_stat;

    // arctangent of 2^-i as a binary angle, 2^31 = pi
    function automatic logic [29:0] f_atan(input logic [4:0] idx);
        logic [29:0] v;
        unique case (idx)
            5'd0:  v = 30'd536870912;
            5'd1:  v = 30'd316933406;
            5'd2:  v = 30'd167458907;
            5'd3:  v = 30'd85004756;
            5'd4:  v = 30'd42667331;
            5'd5:  v = 30'd21354465;
            5'd6:  v = 30'd10679838;
            5'd7:  v = 30'd5340245;
            5'd8:  v = 30'd2670163;
            5'd9:  v = 30'd1335087;
            5'd10: v = 30'd667544;
            5'd11: v = 30'd333772;
            5'd12: v = 30'd166886;
            5'd13: v = 30'd83443;
            5'd14: v = 30'd41722;
            5'd15: v = 30'd20861;
            5'd16: v = 30'd10430;
            5'd17: v = 30'd5215;
            5'd18: v = 30'd2608;
            5'd19: v = 30'd1304;
            5'd20: v = 30'd652;
            5'd21: v = 30'd326;
            5'd22: v = 30'd163;
            5'd23: v = 30'd81;
            5'd24: v = 30'd41;
            5'd25: v = 30'd20;
            5'd26: v = 30'd10;
            5'd27: v = 30'd5;
            5'd28: v = 30'd3;
            5'd29: v = 30'd1;
            5'd30: v = 30'd1;
            5'd31: v = 30'd0;
        endcase
        return v;
    endfunction

endpackage

// ===== rtl/differential_drive_odometry_core.sv =====
// Differential-drive odometry core. Each item carries the absolute left and right
// wheel angles; the core turns the wrapped angle steps into wheel travel, works out
// the arc chord and moves the stored pose, returning one result item (x, y, heading,
// saturation flag) per input item. Items are handled one at a time. When the half
// turn is small enough for the series form, the chord factor comes from the series;
// otherwise it takes a CORDIC rotation of the half turn and a second division. The
// time is set by the bit-serial divider and the iterative CORDIC. A finished result
// waits in an output register, and the next item is taken while it waits.
// Configuration is written through a plain write port; the user must write it only
// while the core is idle, which the block itself does not enforce. Unknown indexes
// are ignored.
// Depends on ddo_pkg, ddo_ctrl and ddo_dp.
module differential_drive_odometry_core #(
    parameter int CORDIC_STEPS = 24,
    parameter int ANGLE_BITS   = 32
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [1:0]        i_cfg_index,
    input  logic [23:0]       i_cfg_data,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  ddo_pkg::t_odo_in  i_in_item,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output ddo_pkg::t_odo_out o_out_item
);

    ddo_pkg::t_odo_cmd  w_cmd;
    ddo_pkg::t_odo_stat w_stat;

    // sequencer
    ddo_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    // arithmetic and state
    ddo_dp #(
        .CORDIC_STEPS (CORDIC_STEPS),
        .ANGLE_BITS   (ANGLE_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_item   (i_in_item),
        .i_cmd       (w_cmd),
        .o_stat      (w_stat),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item)
    );

endmodule

// ===== rtl/ddo_div.sv =====
// bit-serial signed divider, quotient truncated toward zero
// depends on nothing
module ddo_div (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic signed [63:0] i_num,
    input  logic signed [63:0] i_den,
    output logic               o_done,
    output logic signed [63:0] o_quot
);

    localparam int DW = 64;
    localparam int CW = $clog2(DW);
    localparam logic [CW-1:0] LAST = CW'(DW - 1);

    logic [63:0]   r_num;
    logic [63:0]   r_den;
    logic [64:0]   r_rem;
    logic [63:0]   r_q;
    logic          r_neg;
    logic [CW-1:0] r_cnt;
    logic          r_busy;
    logic          r_done;

    logic [64:0] w_trial;
    logic [64:0] w_diff;
    logic        w_ge;

    // one restoring step a cycle
    always_comb begin
        w_trial = {r_rem[63:0], r_num[63]};
        w_diff  = w_trial - {1'b0, r_den};
        w_ge    = (w_trial >= {1'b0, r_den});
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                if (r_cnt == LAST) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt + 1'b1;
                end
            end
        end
    end

    // magnitudes and partial remainder
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= i_num[63] ? 64'(-i_num) : i_num;
            r_den <= i_den[63] ? 64'(-i_den) : i_den;
            r_rem <= '0;
            r_q   <= '0;
            r_neg <= i_num[63] ^ i_den[63];
        end else if (r_busy) begin
            r_rem <= w_ge ? w_diff : w_trial;
            r_q   <= {r_q[62:0], w_ge};
            r_num <= {r_num[62:0], 1'b0};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_neg ? -$signed(r_q) : $signed(r_q);

endmodule

// ===== rtl/ddo_cordic.sv =====
// iterative rotation-mode cordic giving cosine and sine in Q30
// depends on ddo_pkg for the gain and the arctangent table
module ddo_cordic #(
    parameter int CORDIC_STEPS = 24,
    parameter int ANGLE_BITS   = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic [31:0]        i_angle,
    output logic               o_done,
    output logic signed [33:0] o_cos,
    output logic signed [33:0] o_sin
);

    localparam int IW = $clog2(CORDIC_STEPS);
    localparam logic [IW-1:0] LAST     = IW'(CORDIC_STEPS - 1);
    localparam logic [31:0]   ANG_MASK = 32'hFFFF_FFFF << (32 - ANGLE_BITS);

    logic signed [33:0] r_x;
    logic signed [33:0] r_y;
    logic signed [33:0] r_z;
    logic [IW-1:0]      r_i;
    logic               r_flip;
    logic               r_busy;
    logic               r_done;

    logic [31:0]        w_ang;
    logic [31:0]        w_turn;
    logic [31:0]        w_z0;
    logic               w_flip;
    logic signed [33:0] w_xs;
    logic signed [33:0] w_ys;
    logic signed [33:0] w_at;

    // fold the angle into the right half plane
    always_comb begin
        w_ang  = i_angle & ANG_MASK;
        w_turn = w_ang + 32'h4000_0000;
        w_flip = w_turn[31];
        w_z0   = w_flip ? (w_ang ^ 32'h8000_0000) : w_ang;
    end

    // shifted terms of this step
    always_comb begin
        w_xs = r_x >>> r_i;
        w_ys = r_y >>> r_i;
        w_at = $signed({4'b0, ddo_pkg::f_atan(5'(r_i))});
    end

    // step counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_i    <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_i    <= '0;
            end else if (r_busy) begin
                if (r_i == LAST) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_i <= r_i + 1'b1;
                end
            end
        end
    end

    // micro-rotations
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_x    <= ddo_pkg::CORDIC_GAIN;
            r_y    <= '0;
            r_z    <= {{2{w_z0[31]}}, w_z0};
            r_flip <= w_flip;
        end else if (r_busy) begin
            if (!r_z[33]) begin
                r_x <= r_x - w_ys;
                r_y <= r_y + w_xs;
                r_z <= r_z - w_at;
            end else begin
                r_x <= r_x + w_ys;
                r_y <= r_y - w_xs;
                r_z <= r_z + w_at;
            end
        end
    end

    assign o_done = r_done;
    assign o_cos  = r_flip ? -r_x : r_x;
    assign o_sin  = r_flip ? -r_y : r_y;

endmodule

// ===== rtl/ddo_ctrl.sv =====
// sequencer of the odometry update: one item at a time
// depends on ddo_pkg for states, commands and status
module ddo_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  ddo_pkg::t_odo_stat i_stat,
    output ddo_pkg::t_odo_cmd  o_cmd
);

    ddo_pkg::t_odo_state r_state;
    ddo_pkg::t_odo_state n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ddo_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ddo_pkg::S_IDLE: if (i_in_valid) n_state = ddo_pkg::S_ML;
            ddo_pkg::S_ML:   n_state = ddo_pkg::S_MR;
            ddo_pkg::S_MR:   n_state = ddo_pkg::S_RD;
            ddo_pkg::S_RD:   n_state = ddo_pkg::S_MH;
            ddo_pkg::S_MH:   n_state = ddo_pkg::S_D1S;
            ddo_pkg::S_D1S:  n_state = ddo_pkg::S_D1W;
            ddo_pkg::S_D1W:  if (i_stat.div_done) n_state = ddo_pkg::S_SEL;
            ddo_pkg::S_SEL:  n_state = i_stat.small_turn ? ddo_pkg::S_MK : ddo_pkg::S_C1W;
            ddo_pkg::S_MK:   n_state = ddo_pkg::S_MKH;
            ddo_pkg::S_MKH:  n_state = ddo_pkg::S_FS;
            ddo_pkg::S_FS:   n_state = ddo_pkg::S_MC;
            ddo_pkg::S_C1W:  if (i_stat.cor_done) n_state = ddo_pkg::S_MSB;
            ddo_pkg::S_MSB:  n_state = ddo_pkg::S_D2S;
            ddo_pkg::S_D2S:  n_state = ddo_pkg::S_D2W;
            ddo_pkg::S_D2W:  if (i_stat.div_done) n_state = ddo_pkg::S_MC;
            ddo_pkg::S_MC:   n_state = ddo_pkg::S_CC;
            ddo_pkg::S_CC:   n_state = ddo_pkg::S_C2W;
            ddo_pkg::S_C2W:  if (i_stat.cor_done) n_state = ddo_pkg::S_MX;
            ddo_pkg::S_MX:   n_state = ddo_pkg::S_MY;
            ddo_pkg::S_MY:   n_state = ddo_pkg::S_FIN;
            ddo_pkg::S_FIN:  if (i_stat.out_free) n_state = ddo_pkg::S_IDLE;
            default:         n_state = ddo_pkg::S_IDLE;
        endcase
    end

    // commands
    always_comb begin
        o_cmd        = '0;
        o_cmd.mul_op = ddo_pkg::MUL_NONE;
        o_in_ready   = 1'b0;
        unique case (r_state)
            ddo_pkg::S_IDLE: begin
                o_in_ready   = 1'b1;
                o_cmd.cap_in = i_in_valid;
            end
            ddo_pkg::S_ML:  o_cmd.mul_op = ddo_pkg::MUL_L;
            ddo_pkg::S_MR: begin
                o_cmd.ld_l   = 1'b1;
                o_cmd.mul_op = ddo_pkg::MUL_R;
            end
            ddo_pkg::S_RD:  o_cmd.ld_r = 1'b1;
            ddo_pkg::S_MH:  o_cmd.mul_op = ddo_pkg::MUL_H;
            ddo_pkg::S_D1S: o_cmd.div_start = 1'b1;
            ddo_pkg::S_D1W: o_cmd.ld_h = i_stat.div_done;
            ddo_pkg::S_SEL: o_cmd.cor_start = !i_stat.small_turn;
            ddo_pkg::S_MK:  o_cmd.mul_op = ddo_pkg::MUL_HK;
            ddo_pkg::S_MKH: o_cmd.mul_op = ddo_pkg::MUL_HKH;
            ddo_pkg::S_FS:  o_cmd.ld_f_small = 1'b1;
            ddo_pkg::S_C1W: ;
            ddo_pkg::S_MSB: o_cmd.mul_op = ddo_pkg::MUL_SB;
            ddo_pkg::S_D2S: begin
                o_cmd.div_start = 1'b1;
                o_cmd.div_for_f = 1'b1;
            end
            ddo_pkg::S_D2W: o_cmd.ld_f_div = i_stat.div_done;
            ddo_pkg::S_MC:  o_cmd.mul_op = ddo_pkg::MUL_LRF;
            ddo_pkg::S_CC: begin
                o_cmd.ld_c      = 1'b1;
                o_cmd.cor_start = 1'b1;
                o_cmd.cor_dir   = 1'b1;
            end
            ddo_pkg::S_C2W: ;
            ddo_pkg::S_MX:  o_cmd.mul_op = ddo_pkg::MUL_CX;
            ddo_pkg::S_MY: begin
                o_cmd.ld_x   = 1'b1;
                o_cmd.mul_op = ddo_pkg::MUL_CY;
            end
            ddo_pkg::S_FIN: o_cmd.commit = i_stat.out_free;
            default: ;
        endcase
    end

endmodule

// ===== rtl/ddo_dp.sv =====
// odometry datapath: registers, pose state, shared multiplier, divider and cordic
// depends on ddo_pkg, ddo_div and ddo_cordic
module ddo_dp #(
    parameter int CORDIC_STEPS = 24,
    parameter int ANGLE_BITS   = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_index,
    input  logic [23:0]        i_cfg_data,
    input  ddo_pkg::t_odo_in   i_in_item,
    input  ddo_pkg::t_odo_cmd  i_cmd,
    output ddo_pkg::t_odo_stat o_stat,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output ddo_pkg::t_odo_out  o_out_item
);

    // configuration and pose state
    logic [23:0]        r_scale_l;
    logic [23:0]        r_scale_r;
    logic [23:0]        r_half_track;
    logic [31:0]        r_prev_l;
    logic [31:0]        r_prev_r;
    logic signed [31:0] r_pose_x;
    logic signed [31:0] r_pose_y;
    logic [31:0]        r_heading;

    // working registers
    logic signed [31:0] r_dl;
    logic signed [31:0] r_dr;
    logic signed [31:0] r_l;
    logic signed [31:0] r_r;
    logic signed [63:0] r_h;
    logic signed [33:0] r_f;
    logic signed [35:0] r_c;
    logic signed [31:0] r_nx;
    logic               r_sat_x;
    logic signed [73:0] r_prod;

    ddo_pkg::t_odo_out  r_out_item;
    logic               r_out_valid;

    logic signed [39:0] w_ma;
    logic signed [33:0] w_mb;
    logic signed [73:0] w_prod;
    logic signed [32:0] w_lr_sum;
    logic signed [32:0] w_lr_dif;
    logic [24:0]        w_ht2;
    logic signed [63:0] w_den;
    logic signed [63:0] w_quot;
    logic               w_div_done;
    logic [31:0]        w_cor_ang;
    logic               w_cor_done;
    logic signed [33:0] w_cos;
    logic signed [33:0] w_sin;
    logic signed [43:0] w_dxy;
    logic signed [44:0] w_sum_x;
    logic signed [44:0] w_sum_y;
    logic [32:0]        w_clip_x;
    logic [32:0]        w_clip_y;

    // wheel travel: round, shift out the fraction and saturate
    function automatic logic signed [31:0] f_wheel(input logic signed [73:0] p);
        logic signed [57:0] s;
        logic signed [41:0] d;
        logic signed [31:0] v;
        s = $signed(p[57:0]) + 58'sd32768;
        d = $signed(s[57:16]);
        if (d > 42'sd2147483647) begin
            v = 32'sh7FFF_FFFF;
        end else if (d < -42'sd2147483647) begin
            v = 32'sh8000_0001;
        end else begin
            v = $signed(d[31:0]);
        end
        return v;
    endfunction

    // clip to 32 bits, top bit flags the clip
    function automatic logic [32:0] f_clip(input logic signed [44:0] v);
        logic [32:0] r;
        if (v > 45'sd2147483647) begin
            r = {1'b1, 32'h7FFF_FFFF};
        end else if (v < -45'sd2147483648) begin
            r = {1'b1, 32'h8000_0000};
        end else begin
            r = {1'b0, v[31:0]};
        end
        return r;
    endfunction

    // operand sums
    always_comb begin
        w_lr_sum = {r_l[31], r_l} + {r_r[31], r_r};
        w_lr_dif = {r_r[31], r_r} - {r_l[31], r_l};
    end

    // shared multiplier operand selection
    always_comb begin
        unique case (i_cmd.mul_op)
            ddo_pkg::MUL_NONE: begin
                w_ma = '0;
                w_mb = '0;
            end
            ddo_pkg::MUL_L: begin
                w_ma = {{8{r_dl[31]}}, r_dl};
                w_mb = {10'b0, r_scale_l};
            end
            ddo_pkg::MUL_R: begin
                w_ma = {{8{r_dr[31]}}, r_dr};
                w_mb = {10'b0, r_scale_r};
            end
            ddo_pkg::MUL_H: begin
                w_ma = {{7{w_lr_dif[32]}}, w_lr_dif};
                w_mb = ddo_pkg::RAD_TO_BAM_HALF;
            end
            ddo_pkg::MUL_HK: begin
                w_ma = {{18{r_h[21]}}, r_h[21:0]};
                w_mb = ddo_pkg::SERIES_K;
            end
            ddo_pkg::MUL_HKH: begin
                w_ma = r_prod[39:0];
                w_mb = {{12{r_h[21]}}, r_h[21:0]};
            end
            ddo_pkg::MUL_SB: begin
                w_ma = {{6{w_sin[33]}}, w_sin};
                w_mb = ddo_pkg::BAM_TO_INV_PI;
            end
            ddo_pkg::MUL_LRF: begin
                w_ma = {{7{w_lr_sum[32]}}, w_lr_sum};
                w_mb = r_f;
            end
            ddo_pkg::MUL_CX: begin
                w_ma = {{4{r_c[35]}}, r_c};
                w_mb = w_cos;
            end
            ddo_pkg::MUL_CY: begin
                w_ma = {{4{r_c[35]}}, r_c};
                w_mb = w_sin;
            end
            default: begin
                w_ma = '0;
                w_mb = '0;
            end
        endcase
        w_prod = w_ma * w_mb;
    end

    // product register
    always_ff @(posedge i_clk) begin
        if (i_cmd.mul_op != ddo_pkg::MUL_NONE) begin
            r_prod <= w_prod;
        end
    end

    // divider operands: twice the half track, or the half turn
    always_comb begin
        w_ht2 = {(r_half_track == 24'd0) ? 24'd1 : r_half_track, 1'b0};
        w_den = i_cmd.div_for_f ? r_h : $signed({39'b0, w_ht2});
    end

    ddo_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_num   ($signed(r_prod[63:0])),
        .i_den   (w_den),
        .o_done  (w_div_done),
        .o_quot  (w_quot)
    );

    // half turn alone, or travel direction
    assign w_cor_ang = i_cmd.cor_dir ? (r_heading + r_h[31:0]) : r_h[31:0];

    ddo_cordic #(
        .CORDIC_STEPS (CORDIC_STEPS),
        .ANGLE_BITS   (ANGLE_BITS)
    ) u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.cor_start),
        .i_angle (w_cor_ang),
        .o_done  (w_cor_done),
        .o_cos   (w_cos),
        .o_sin   (w_sin)
    );

    // pose offsets and clipping
    always_comb begin
        w_dxy    = $signed(r_prod[73:30]);
        w_sum_x  = {{13{r_pose_x[31]}}, r_pose_x} + {w_dxy[43], w_dxy};
        w_sum_y  = {{13{r_pose_y[31]}}, r_pose_y} + {w_dxy[43], w_dxy};
        w_clip_x = f_clip(w_sum_x);
        w_clip_y = f_clip(w_sum_y);
    end

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scale_l    <= ddo_pkg::RST_LEFT_SCALE;
            r_scale_r    <= ddo_pkg::RST_RIGHT_SCALE;
            r_half_track <= ddo_pkg::RST_HALF_TRACK;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                ddo_pkg::CFG_LEFT_SCALE:  r_scale_l    <= i_cfg_data;
                ddo_pkg::CFG_RIGHT_SCALE: r_scale_r    <= i_cfg_data;
                ddo_pkg::CFG_HALF_TRACK:  r_half_track <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // pose state and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_l    <= '0;
            r_prev_r    <= '0;
            r_pose_x    <= '0;
            r_pose_y    <= '0;
            r_heading   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.cap_in) begin
                r_prev_l <= i_in_item.left_angle;
                r_prev_r <= i_in_item.right_angle;
            end
            if (i_cmd.commit) begin
                r_pose_x    <= r_nx;
                r_pose_y    <= $signed(w_clip_y[31:0]);
                r_heading   <= r_heading + {r_h[30:0], 1'b0};
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.cap_in) begin
            r_dl <= i_in_item.left_angle - $signed(r_prev_l);
            r_dr <= i_in_item.right_angle - $signed(r_prev_r);
        end
        if (i_cmd.ld_l) r_l <= f_wheel(r_prod);
        if (i_cmd.ld_r) r_r <= f_wheel(r_prod);
        if (i_cmd.ld_h) r_h <= w_quot;
        if (i_cmd.ld_f_small) begin
            r_f <= 34'sh0_4000_0000 - $signed({23'b0, r_prod[58:48]});
        end else if (i_cmd.ld_f_div) begin
            r_f <= w_quot[33:0];
        end
        if (i_cmd.ld_c) r_c <= $signed(r_prod[66:31]);
        if (i_cmd.ld_x) begin
            r_nx    <= $signed(w_clip_x[31:0]);
            r_sat_x <= w_clip_x[32];
        end
        if (i_cmd.commit) begin
            r_out_item.x_position     <= r_nx;
            r_out_item.y_position     <= $signed(w_clip_y[31:0]);
            r_out_item.heading        <= r_heading + {r_h[30:0], 1'b0};
            r_out_item.pose_saturated <= r_sat_x | w_clip_y[32];
        end
    end

    // status back to the controller
    always_comb begin
        o_stat.div_done   = w_div_done;
        o_stat.cor_done   = w_cor_done;
        o_stat.small_turn = (r_h > -64'sd2097152) && (r_h < 64'sd2097152);
        o_stat.out_free   = !r_out_valid || i_out_ready;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule

// ===== rtl/ddo_checker.sv =====
// port-level checks of the odometry core, bound to the top level
// depends on ddo_pkg and the assertion macro header
`include "differential_drive_odometry_core_macros.svh"

module ddo_checker (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_in_valid,
    input logic              o_in_ready,
    input logic              o_out_valid,
    input logic              i_out_ready,
    input ddo_pkg::t_odo_out o_out_item
);

    // a stalled result holds
    `DDO_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready, o_out_valid && $stable(o_out_item), "result changed while stalled")

    // one item at a time: busy right after acceptance
    `DDO_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, i_in_valid && o_in_ready, !o_in_ready, "item taken while busy")

    // a new result only comes from a busy core
    `DDO_ASSERT_SAME(a_result_from_work, i_clk, i_rst_n, $rose(o_out_valid), !$past(o_in_ready), "result without work")

    // saturation flag only with a coordinate at its limit
    `DDO_ASSERT_SAME(a_sat_at_limit, i_clk, i_rst_n, o_out_valid && o_out_item.pose_saturated, o_out_item.x_position == 32'sh7FFF_FFFF || o_out_item.x_position == 32'sh8000_0000 || o_out_item.y_position == 32'sh7FFF_FFFF || o_out_item.y_position == 32'sh8000_0000, "saturation flag without clipped coordinate")

endmodule

bind differential_drive_odometry_core ddo_checker u_ddo_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_item  (o_out_item)
);

// ===== tb/sv/differential_drive_odometry_core_checker.sv =====
// channel monitor and pose predictor for the odometry core testbench
// depends on ddo_pkg for the payload types and register indexes
module differential_drive_odometry_core_checker (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [1:0]        i_cfg_index,
    input  logic [23:0]       i_cfg_data,
    input  logic              i_in_valid,
    input  logic              i_in_ready,
    input  ddo_pkg::t_odo_in  i_in_item,
    input  logic              i_out_valid,
    input  logic              i_out_ready,
    input  ddo_pkg::t_odo_out i_out_item,
    output int                o_fail_count,
    output int                o_pending
);

    localparam int     ROT_STEPS   = 24;
    localparam longint ROT_GAIN    = 64'sd652032875;
    localparam longint HALF_TURN_K = 64'sd341782638;
    localparam longint INV_PI_K    = 64'sd683565276;
    localparam longint SINC_K      = 64'sd107802;
    localparam longint SERIES_EDGE = 64'sd2097152;
    localparam longint TRAVEL_MAX  = 64'sd2147483647;

    localparam longint ARCTAN [32] = '{
        536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
        10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
        41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20,
        10, 5, 3, 1, 1, 0
    };

    // model copy of the registers and the pose
    logic [23:0]       left_scale, right_scale, half_track;
    logic [31:0]       left_last, right_last, heading_now;
    longint            x_now, y_now;
    ddo_pkg::t_odo_out expected_poses[$];
    int                fail_count;

    assign o_fail_count = fail_count;
    assign o_pending    = expected_poses.size();

    // rotation-mode cordic, unit vector scaled to q30
    task automatic rotate_unit(input logic [31:0] ang, output longint co, output longint si);
        logic   flip;
        longint xv, yv, zv, nx;
        flip = ang[31] ^ ang[30];
        if (flip) ang[31] = ~ang[31];
        zv = longint'($signed(ang));
        xv = ROT_GAIN;
        yv = 0;
        for (int i = 0; i < ROT_STEPS; i++) begin
            if (zv >= 0) begin
                nx = xv - (yv >>> i);
                yv = yv + (xv >>> i);
                zv = zv - ARCTAN[i];
            end else begin
                nx = xv + (yv >>> i);
                yv = yv - (xv >>> i);
                zv = zv + ARCTAN[i];
            end
            xv = nx;
        end
        co = flip ? -xv : xv;
        si = flip ? -yv : yv;
    endtask

    // wrapped angle step scaled to wheel travel, clamped
    function automatic longint wheel_travel(logic [31:0] now, logic [31:0] prev,
                                            logic [23:0] scale);
        logic [31:0] step;
        longint      d;
        step = now - prev;
        d = (longint'($signed(step)) * longint'({40'd0, scale}) + 32768) >>> 16;
        if (d > TRAVEL_MAX) d = TRAVEL_MAX;
        if (d < -TRAVEL_MAX) d = -TRAVEL_MAX;
        return d;
    endfunction

    function automatic longint clip_pose(longint v, inout logic sat);
        if (v > 64'sd2147483647) begin
            sat = 1'b1;
            return 64'sd2147483647;
        end
        if (v < -64'sd2147483648) begin
            sat = 1'b1;
            return -64'sd2147483648;
        end
        return v;
    endfunction

    // one odometry update; returns the expected result item
    task automatic advance_pose(input ddo_pkg::t_odo_in it, output ddo_pkg::t_odo_out res);
        longint      l, r, ht, h, ah, f, c, co, si;
        logic [63:0] sq;
        logic [31:0] hu;
        logic        sat;
        sat = 1'b0;
        l = wheel_travel(it.left_angle, left_last, left_scale);
        r = wheel_travel(it.right_angle, right_last, right_scale);
        ht = (half_track == 0) ? 1 : longint'({40'd0, half_track});
        h = ((r - l) * HALF_TURN_K) / (2 * ht);
        hu = h[31:0];
        ah = (h < 0) ? -h : h;
        if (ah < SERIES_EDGE) begin
            sq = h * h * SINC_K;
            f = 64'sd1073741824 - longint'(sq >> 48);
        end else begin
            rotate_unit(hu, co, si);
            f = (si * INV_PI_K) / h;
        end
        c = ((l + r) * f) >>> 31;
        rotate_unit(heading_now + hu, co, si);
        x_now = clip_pose(x_now + ((c * co) >>> 30), sat);
        y_now = clip_pose(y_now + ((c * si) >>> 30), sat);
        heading_now = heading_now + (hu << 1);
        left_last = it.left_angle;
        right_last = it.right_angle;
        res.x_position = x_now[31:0];
        res.y_position = y_now[31:0];
        res.heading = heading_now;
        res.pose_saturated = sat;
    endtask

    // watch configuration, input and output channels
    always @(posedge i_clk) begin
        ddo_pkg::t_odo_out want;
        if (!i_rst_n) begin
            left_scale <= ddo_pkg::RST_LEFT_SCALE;
            right_scale <= ddo_pkg::RST_RIGHT_SCALE;
            half_track <= ddo_pkg::RST_HALF_TRACK;
            left_last = '0;
            right_last = '0;
            heading_now = '0;
            x_now = 0;
            y_now = 0;
            expected_poses.delete();
            fail_count = 0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    ddo_pkg::CFG_LEFT_SCALE:  left_scale <= i_cfg_data;
                    ddo_pkg::CFG_RIGHT_SCALE: right_scale <= i_cfg_data;
                    ddo_pkg::CFG_HALF_TRACK:  half_track <= i_cfg_data;
                    default: ;
                endcase
            end
            if (i_in_valid && i_in_ready) begin
                advance_pose(i_in_item, want);
                expected_poses.push_back(want);
            end
            if (i_out_valid && i_out_ready) begin
                if (expected_poses.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("unexpected result item %p", i_out_item);
                end else begin
                    want = expected_poses.pop_front();
                    if (i_out_item.x_position !== want.x_position ||
                        i_out_item.y_position !== want.y_position ||
                        i_out_item.heading !== want.heading ||
                        i_out_item.pose_saturated !== want.pose_saturated) begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("pose mismatch: expected x %0d y %0d hd %h sat %b, got x %0d y %0d hd %h sat %b",
                                want.x_position, want.y_position, want.heading,
                                want.pose_saturated, i_out_item.x_position,
                                i_out_item.y_position, i_out_item.heading,
                                i_out_item.pose_saturated);
                    end
                end
            end
        end
    end

endmodule

// ===== tb/sv/differential_drive_odometry_core_tb.sv =====
// top of the odometry core testbench: clock, reset, wheel angle stimulus, verdict
// depends on ddo_pkg, differential_drive_odometry_core and its checker module
module differential_drive_odometry_core_tb;

    localparam logic [1:0] CFG_SPARE = 2'd3;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int SETTLE = 250;

    logic              i_clk;
    logic              i_rst_n;
    logic              i_cfg_we;
    logic [1:0]        i_cfg_index;
    logic [23:0]       i_cfg_data;
    logic              i_in_valid;
    logic              o_in_ready;
    ddo_pkg::t_odo_in  i_in_item;
    logic              o_out_valid;
    logic              i_out_ready;
    ddo_pkg::t_odo_out o_out_item;
    int                fail_count, pending;
    logic              hold_request;
    logic              no_idling;
    logic [31:0]       left_pos, right_pos;

    differential_drive_odometry_core dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data),
        .i_in_valid(i_in_valid), .o_in_ready(o_in_ready), .i_in_item(i_in_item),
        .o_out_valid(o_out_valid), .i_out_ready(i_out_ready), .o_out_item(o_out_item)
    );

    differential_drive_odometry_core_checker checker_i (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data),
        .i_in_valid(i_in_valid), .i_in_ready(o_in_ready), .i_in_item(i_in_item),
        .i_out_valid(o_out_valid), .i_out_ready(i_out_ready), .i_out_item(o_out_item),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    initial i_clk = 1'b0;
    always #4 i_clk = ~i_clk;

    function automatic int gap_length();
        int p;
        p = $urandom_range(0, 99);
        if (no_idling || p < 60) return 0;
        if (p < 92) return $urandom_range(1, 3);
        return $urandom_range(20, 90);
    endfunction

    // offer one item and hold it until accepted, then maybe idle
    task automatic send_angles(input logic [31:0] la, input logic [31:0] ra);
        int g;
        i_in_valid <= 1'b1;
        i_in_item.left_angle <= la;
        i_in_item.right_angle <= ra;
        do @(posedge i_clk); while (!o_in_ready);
        left_pos = la;
        right_pos = ra;
        g = gap_length();
        if (g > 0) begin
            i_in_valid <= 1'b0;
            repeat (g) @(posedge i_clk);
        end
    endtask

    // drop valid and wait for every result plus the core's own latency
    task automatic drain();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    // write all registers on consecutive edges, plus the unused index
    task automatic write_registers(input logic [23:0] ls, input logic [23:0] rs,
                                   input logic [23:0] ht);
        i_cfg_we <= 1'b1;
        i_cfg_index <= CFG_SPARE;
        i_cfg_data <= 24'($urandom());
        @(posedge i_clk);
        i_cfg_index <= ddo_pkg::CFG_LEFT_SCALE;
        i_cfg_data <= ls;
        @(posedge i_clk);
        i_cfg_index <= ddo_pkg::CFG_RIGHT_SCALE;
        i_cfg_data <= rs;
        @(posedge i_clk);
        i_cfg_index <= ddo_pkg::CFG_HALF_TRACK;
        i_cfg_data <= ht;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    // mostly plausible wheel motion, some noise and wild jumps
    task automatic random_motion(input int count);
        logic [31:0] dl, dr;
        int          kind;
        for (int n = 0; n < count; n++) begin
            kind = $urandom_range(0, 99);
            dl = $urandom_range(0, 4000) - 2000;
            if (kind < 20) dr = dl;
            else if (kind < 45) dr = dl + $urandom_range(0, 8) - 4;
            else if (kind < 80) dr = $urandom_range(0, 4000) - 2000;
            else if (kind < 90) dr = $urandom_range(0, 400000) - 200000;
            else begin
                dl = $urandom();
                dr = $urandom();
            end
            send_angles(left_pos + dl, right_pos + dr);
        end
    endtask

    // receiver: random stalls, and one long hold-off on request
    initial begin
        int stall;
        i_out_ready = 1'b0;
        stall = 0;
        forever begin
            @(posedge i_clk);
            if (hold_request) begin
                hold_request = 1'b0;
                i_out_ready <= 1'b0;
                repeat (600) @(posedge i_clk);
            end else if (stall > 0) begin
                stall--;
                i_out_ready <= 1'b0;
            end else if (!no_idling && $urandom_range(0, 99) < 25) begin
                stall = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 120)
                                                    : $urandom_range(1, 4);
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    // run limit
    initial begin
        repeat (CYCLE_LIMIT) @(posedge i_clk);
        $display("Test completed with failures");
        $finish;
    end

    initial begin
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_index = ddo_pkg::CFG_LEFT_SCALE;
        i_cfg_data = '0;
        i_in_valid = 1'b0;
        i_in_item = '0;
        hold_request = 1'b0;
        no_idling = 1'b0;
        left_pos = '0;
        right_pos = '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: reset registers, straight moves, turns, field extremes
        send_angles(32'd0, 32'd0);
        send_angles(32'd100, 32'd100);
        send_angles(32'd110, 32'd130);
        send_angles(32'd100, 32'd160);
        send_angles(32'h7fff_ffff, 32'h8000_0000);
        send_angles(32'h8000_0000, 32'h7fff_ffff);
        send_angles(32'hffff_ffff, 32'h0000_0000);
        send_angles(32'h5555_5555, 32'haaaa_aaaa);
        send_angles(32'haaaa_aaaa, 32'h5555_5555);
        drain();

        // zero track width and huge wheel travel until the pose clips
        write_registers(24'hffffff, 24'hffffff, 24'd0);
        send_angles(left_pos + 32'h7000_0000, right_pos + 32'h7000_0000);
        send_angles(left_pos + 32'h7000_0000, right_pos + 32'h7000_0000);
        send_angles(left_pos + 32'h7000_0000, right_pos + 32'h7000_0000);
        send_angles(left_pos + 32'h9000_0000, right_pos + 32'h9000_0000);
        send_angles(left_pos + 32'h9000_0000, right_pos + 32'h9000_0000);
        send_angles(left_pos + 32'h9000_0000, right_pos + 32'h9000_0000);
        send_angles(left_pos + 32'h0000_0100, right_pos + 32'h0000_0200);
        random_motion(40);
        drain();

        // smallest scales and track
        write_registers(24'd0, 24'd1, 24'd1);
        send_angles(left_pos + 32'd5, right_pos + 32'd70000);
        random_motion(40);
        drain();

        // trimmed left wheel, widest track; receiver holds off while items pile up
        write_registers(24'd734003, 24'd655360, 24'hffffff);
        hold_request = 1'b1;
        no_idling = 1'b1;
        random_motion(20);
        no_idling = 1'b0;
        random_motion(60);
        drain();

        // typical robot geometry, burst without idling then random idling
        write_registers(24'd734003, 24'd655360, 24'd25600);
        no_idling = 1'b1;
        random_motion(50);
        no_idling = 1'b0;
        random_motion(100);
        drain();

        // random settings
        write_registers(24'($urandom()), 24'($urandom()),
                        24'($urandom_range(1, 200000)));
        random_motion(60);
        drain();
        write_registers(24'($urandom_range(0, 2000000)), 24'($urandom_range(0, 2000000)),
                        24'($urandom_range(0, 3)));
        random_motion(60);
        drain();

        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
